// ===== rtl/core/lph_pkg.sv =====
// Shared types, codes and defaults for the linear probing hash table.
`timescale 1ns / 1ps

package lph_pkg;

    localparam int unsigned SLOTS_DEF     = 128;
    localparam int unsigned KEY_BYTES_DEF = 8;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLOT_W   = 7;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] RS_FOUND      = 3'd0;
    localparam logic [STATUS_W-1:0] RS_ABSENT     = 3'd1;
    localparam logic [STATUS_W-1:0] RS_INSERTED   = 3'd2;
    localparam logic [STATUS_W-1:0] RS_PRESENT    = 3'd3;
    localparam logic [STATUS_W-1:0] RS_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] RS_DELETED    = 3'd5;
    localparam logic [STATUS_W-1:0] RS_DEL_ABSENT = 3'd6;
    localparam logic [STATUS_W-1:0] RS_EMPTY_KEY  = 3'd7;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_QUOT,
        CS_HOME,
        CS_READ,
        CS_CHECK
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic quot;
        logic home;
        logic read;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic key_zero;
        logic stop;
    } sts_t;

endpackage

// ===== rtl/core/lph_ctrl.sv =====
// Controller state machine that sequences clearing, hashing and probing.
`timescale 1ns / 1ps

module lph_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lph_pkg::sts_t sts,
    output lph_pkg::cmd_t cmd,
    output logic          busy
);
    import lph_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            CS_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_QUOT;
                end
            end
            CS_QUOT:
            begin
                if (sts.key_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
                else
                begin
                    cmd.quot   = 1'b1;
                    state_next = CS_HOME;
                end
            end
            CS_HOME:
            begin
                cmd.home   = 1'b1;
                state_next = CS_READ;
            end
            CS_READ:
            begin
                cmd.read   = 1'b1;
                state_next = CS_CHECK;
            end
            CS_CHECK:
            begin
                if (sts.stop)
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lph_dp.sv =====
// Datapath: key cleaning, home slot hashing, slot stores and result register.
`timescale 1ns / 1ps

module lph_dp #(
    parameter int unsigned SLOTS     = lph_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lph_pkg::cmd_t cmd,
    input  lph_pkg::req_t request,
    output lph_pkg::sts_t sts,
    output lph_pkg::rsp_t result,
    output logic          done
);
    import lph_pkg::*;

    localparam int unsigned IDX_W  = $clog2(SLOTS);
    localparam int unsigned CKEY_W = 8 * KEY_BYTES;
    localparam int unsigned SUM_W  = $clog2(255 * KEY_BYTES + 1);
    localparam int unsigned RECIP  = (2 ** SUM_W) / SLOTS;
    localparam int unsigned CMP_W  = (SUM_W > IDX_W + 1) ? SUM_W : IDX_W + 1;
    localparam int unsigned PROD_W = SUM_W + CMP_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CMP_W-1:0] SLOTS_C  = CMP_W'(SLOTS);
    localparam logic [SUM_W-1:0] RECIP_V  = SUM_W'(RECIP);

    logic [1:0]        mark_mem [SLOTS];
    logic [CKEY_W-1:0] key_mem  [SLOTS];

    logic [ACTION_W-1:0] act_reg;
    logic [CKEY_W-1:0]   key_reg;
    logic                kz_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    quot_reg;
    logic [IDX_W-1:0]    home_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    step_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_reg;
    logic [IDX_W-1:0]    clr_reg;
    logic [1:0]          mark_rd_reg;
    logic [CKEY_W-1:0]   key_rd_reg;
    rsp_t                rsp_reg;
    logic                done_reg;

    logic [CKEY_W-1:0]      ckey;
    logic [SUM_W-1:0]       sum_next;
    logic [7:0]             byte_v;
    logic                   alive;
    logic [2*SUM_W-1:0]     prod;
    logic [PROD_W-1:0]      qn;
    logic [SUM_W-1:0]       rem;
    logic [CMP_W-1:0]       rem_c;
    logic [CMP_W-1:0]       home_c;
    logic [IDX_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       rd_addr;
    logic                   hit;
    logic                   cur_free;
    logic [IDX_W-1:0]       fin_idx;
    logic [STATUS_W-1:0]    fin_status;
    logic                   fin_mark_we;
    logic [1:0]             fin_mark;
    logic                   fin_key_we;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic                   mark_we;
    logic [IDX_W-1:0]       mark_wa;
    logic [1:0]             mark_wd;

    // The key ends at its first zero byte; only the live bytes are kept and summed.
    always_comb
    begin
        alive    = 1'b1;
        ckey     = '0;
        sum_next = '0;
        byte_v   = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            byte_v = request.key[8*i +: 8];
            alive  = alive && (byte_v != 8'd0);
            if (alive)
            begin
                ckey[8*i +: 8] = byte_v;
                sum_next       = sum_next + SUM_W'(byte_v);
            end
        end
    end

    // The reciprocal estimate of the quotient is low by at most one.
    assign prod   = {{SUM_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP_V};
    assign qn     = PROD_W'(quot_reg) * PROD_W'(SLOTS);
    assign rem    = sum_reg - qn[SUM_W-1:0];
    assign rem_c  = CMP_W'(rem);
    assign home_c = (rem_c >= SLOTS_C) ? (rem_c - SLOTS_C) : rem_c;

    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
    assign rd_addr = cmd.advance ? idx_inc : idx_reg;

    assign hit      = (mark_rd_reg == MARK_USED) && (key_rd_reg == key_reg);
    assign cur_free = (mark_rd_reg != MARK_USED);

    assign sts.clr_last = (clr_reg == LAST_IDX);
    assign sts.key_zero = kz_reg;
    assign sts.stop     = hit || (mark_rd_reg == MARK_EMPTY) || (step_reg == LAST_IDX);

    always_comb
    begin
        fin_idx     = home_reg;
        fin_status  = RS_ABSENT;
        fin_mark_we = 1'b0;
        fin_mark    = MARK_USED;
        fin_key_we  = 1'b0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    fin_status = RS_PRESENT;
                    fin_idx    = idx_reg;
                end
                else if (free_found_reg || cur_free)
                begin
                    fin_status  = RS_INSERTED;
                    fin_idx     = free_found_reg ? free_reg : idx_reg;
                    fin_mark_we = 1'b1;
                    fin_key_we  = 1'b1;
                end
                else
                begin
                    fin_status = RS_FULL;
                end
            end
            ACT_DELETE:
            begin
                if (hit)
                begin
                    fin_status  = RS_DELETED;
                    fin_idx     = idx_reg;
                    fin_mark_we = 1'b1;
                    fin_mark    = MARK_DELETED;
                end
                else
                begin
                    fin_status = RS_DEL_ABSENT;
                end
            end
            default:
            begin
                if (hit)
                begin
                    fin_status = RS_FOUND;
                    fin_idx    = idx_reg;
                end
                else
                begin
                    fin_status = RS_ABSENT;
                end
            end
        endcase
        if (kz_reg)
        begin
            fin_status  = RS_EMPTY_KEY;
            fin_idx     = '0;
            fin_mark_we = 1'b0;
            fin_key_we  = 1'b0;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, fin_idx};

    assign mark_we = cmd.clear || (cmd.finish && fin_mark_we);
    assign mark_wa = cmd.clear ? clr_reg : fin_idx;
    assign mark_wd = cmd.clear ? MARK_EMPTY : fin_mark;

    always_ff @(posedge clk)
    begin
        if (cmd.read || cmd.advance)
        begin
            mark_rd_reg <= mark_mem[rd_addr];
        end
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read || cmd.advance)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
        if (cmd.finish && fin_key_we)
        begin
            key_mem[fin_idx] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= request.action;
            key_reg <= ckey;
            kz_reg  <= (ckey == '0);
            sum_reg <= sum_next;
        end
        if (cmd.quot)
        begin
            quot_reg <= prod[2*SUM_W-1:SUM_W];
        end
        if (cmd.home)
        begin
            home_reg       <= home_c[IDX_W-1:0];
            idx_reg        <= home_c[IDX_W-1:0];
            step_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        if (cmd.advance)
        begin
            idx_reg  <= idx_inc;
            step_reg <= step_reg + IDX_W'(1);
            if (!free_found_reg && cur_free)
            begin
                free_found_reg <= 1'b1;
                free_reg       <= idx_reg;
            end
        end
        if (cmd.finish)
        begin
            rsp_reg.status <= fin_status;
            rsp_reg.slot   <= slot_ext[SLOT_W-1:0];
        end
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// Top level of the hash table with linear probing and deleted-slot marks.
// A request (action and key) is transferred at a rising edge where start is
// high and busy is low. Its single result appears on result for exactly one
// cycle with done high; the receiver always takes it and cannot stall it.
// An empty key is answered from the quotient step, without probing. Any other
// request probes 1 to SLOTS slots: the key is loaded and cleaned, the
// quotient and then the home slot are computed by reciprocal multiplication,
// the first read is issued, and the probe loop then reads one slot per cycle
// from the registered-read slot memories.
// An insert walks at most the whole table and remembers the first free slot.
// busy falls in the cycle the result is shown, so the next request can be
// transferred while done is high.
// After reset the block clears every slot mark to empty, one slot per cycle,
// which keeps busy high until the last mark is cleared.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
    parameter int unsigned SLOTS     = lph_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lph_pkg::req_t request,
    output logic          done,
    output lph_pkg::rsp_t result
);
    import lph_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lph_dp #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in work");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a transfer");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == RS_EMPTY_KEY)) |-> (result.slot == '0))
        else $error("empty key result with a nonzero slot");

endmodule
